@@ sv/polyline_point_decoder_top_defines.svh @@
// Assertion macros for the polyline point decoder RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef POLYLINE_POINT_DECODER_TOP_DEFINES_SVH
`define POLYLINE_POINT_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PPD_ASSERT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
		else $error("ppd assertion failed");
`define PPD_NEVER(lbl, clk_s, rstn_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
		else $error("ppd forbidden condition seen");
`else
`define PPD_ASSERT(lbl, clk_s, rstn_s, prop)
`define PPD_NEVER(lbl, clk_s, rstn_s, cond)
`endif
`endif

@@ sv/ppd_pkg.sv @@
// Types and constants for the polyline point decoder.
// No dependencies; used by every module of the block.
package ppd_pkg;

	localparam logic [7:0] CHAR_OFFSET = 8'd63;
	localparam logic [7:0] DATA_MASK   = 8'h1f;
	localparam logic [7:0] CONT_LIMIT  = 8'h20;

	localparam int MID_DEPTH = 4;
	localparam int MID_PTR_W = $clog2(MID_DEPTH);
	localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

	localparam int OUT_DEPTH = 2;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	localparam logic [2:0]  CHUNK_MAX = 3'd7;
	localparam logic [15:0] INDEX_MAX = 16'hffff;

	// Classified character as it travels from front to back
	typedef struct packed {
		logic [4:0] data;
		logic       more;
		logic       last;
	} mid_item_t;

	typedef struct packed {
		logic signed [31:0] lat_e5;
		logic signed [31:0] lng_e5;
		logic [15:0]        point_index;
		logic               final_point;
	} result_t;

endpackage

@@ sv/ppd_front.sv @@
// Front end: takes characters, splits off data bits and continuation flag,
// and holds them in a short queue for the back end. Depends on ppd_pkg.
module ppd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [7:0]           char_byte,
	input  logic                 last_char,
	output logic                 full,
	input  logic                 rd_en,
	output logic                 rd_valid,
	output ppd_pkg::mid_item_t   rd_item
);

	ppd_pkg::mid_item_t mem_q [ppd_pkg::MID_DEPTH];
	logic [ppd_pkg::MID_PTR_W-1:0] wr_ptr_q;
	logic [ppd_pkg::MID_PTR_W-1:0] rd_ptr_q;
	logic [ppd_pkg::MID_CNT_W-1:0] cnt_q;
	logic [7:0]                    b;
	ppd_pkg::mid_item_t            item;
	logic                          wr;
	logic                          rd;

	// Offset byte, wrapping modulo 256; continues while it reads as 0x20..0x7f
	always_comb begin
		b         = char_byte - ppd_pkg::CHAR_OFFSET;
		item.data = 5'(b & ppd_pkg::DATA_MASK);
		item.more = !b[7] && (b >= ppd_pkg::CONT_LIMIT);
		item.last = last_char;
	end

	assign full     = (cnt_q == ppd_pkg::MID_CNT_W'(ppd_pkg::MID_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign wr       = push && !full;
	assign rd       = rd_en && rd_valid;
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ sv/ppd_back.sv @@
// Back end: assembles values, zigzag decodes them and keeps the running
// coordinates and point count. Depends on ppd_pkg and the defines header.
`include "polyline_point_decoder_top_defines.svh"
module ppd_back #(
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  ppd_pkg::mid_item_t in_item,
	output logic               in_pop,
	input  logic               out_room,
	output logic               out_push,
	output ppd_pkg::result_t   out_data
);

	localparam int WIDE_W = VALUE_BITS + 35;
	localparam int DZ_W   = (VALUE_BITS > 32) ? VALUE_BITS : 32;

	logic [VALUE_BITS-1:0] acc_q;
	logic [2:0]            chunk_q;
	logic                  doing_lng_q;
	logic [31:0]           lat_q;
	logic [31:0]           lng_q;
	logic [15:0]           idx_q;

	logic                  proc;
	logic [5:0]            shamt;
	logic [WIDE_W-1:0]     wide;
	logic [VALUE_BITS-1:0] acc_new;
	logic [DZ_W-1:0]       half;
	logic [DZ_W-1:0]       zz;
	logic [31:0]           delta;
	logic                  finished;
	logic                  emit;
	logic [31:0]           lat_new;
	logic [31:0]           lng_new;

	assign proc   = in_valid && out_room;
	assign in_pop = proc;

	always_comb begin
		shamt    = 6'(chunk_q) * 6'd5;
		wide     = WIDE_W'(in_item.data) << shamt;
		acc_new  = acc_q | wide[VALUE_BITS-1:0];
		half     = DZ_W'(acc_new) >> 1;
		zz       = acc_new[0] ? ~half : half;
		delta    = zz[31:0];
		finished = !in_item.more || in_item.last;
		lat_new  = lat_q;
		lng_new  = lng_q;
		emit     = 1'b0;
		if (finished) begin
			if (doing_lng_q) begin
				lng_new = lng_q + delta;
				emit    = 1'b1;
			end else begin
				lat_new = lat_q + delta;
				emit    = in_item.last;
			end
		end
	end

	assign out_push             = proc && emit;
	assign out_data.lat_e5      = lat_new;
	assign out_data.lng_e5      = lng_new;
	assign out_data.point_index = idx_q;
	assign out_data.final_point = in_item.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			chunk_q     <= '0;
			doing_lng_q <= 1'b0;
			lat_q       <= '0;
			lng_q       <= '0;
			idx_q       <= '0;
		end else if (proc) begin
			if (in_item.last) begin
				// end of string: drop all state
				acc_q       <= '0;
				chunk_q     <= '0;
				doing_lng_q <= 1'b0;
				lat_q       <= '0;
				lng_q       <= '0;
				idx_q       <= '0;
			end else begin
				lat_q <= lat_new;
				lng_q <= lng_new;
				if (finished) begin
					acc_q       <= '0;
					chunk_q     <= '0;
					doing_lng_q <= !doing_lng_q;
				end else begin
					acc_q <= acc_new;
					if (chunk_q != ppd_pkg::CHUNK_MAX) begin
						chunk_q <= chunk_q + 1'b1;
					end
				end
				if (emit && idx_q != ppd_pkg::INDEX_MAX) begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	`PPD_ASSERT(a_last_clears, clk, arst_n, (proc && in_item.last) |=> (acc_q == '0 && chunk_q == '0 && !doing_lng_q && idx_q == '0 && lat_q == '0 && lng_q == '0))
	`PPD_NEVER(a_push_no_room, clk, arst_n, out_push && !out_room)
	`PPD_ASSERT(a_idx_hold, clk, arst_n, (!proc || (!emit && !in_item.last)) |=> $stable(idx_q))

endmodule

@@ sv/ppd_outq.sv @@
// Result queue: two entries so the back end keeps going while a result waits.
// Depends on ppd_pkg.
module ppd_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  ppd_pkg::result_t wr_data,
	output logic             room,
	input  logic             pop,
	output logic             empty,
	output ppd_pkg::result_t rd_data
);

	ppd_pkg::result_t mem_q [ppd_pkg::OUT_DEPTH];
	logic [ppd_pkg::OUT_PTR_W-1:0] wr_ptr_q;
	logic [ppd_pkg::OUT_PTR_W-1:0] rd_ptr_q;
	logic [ppd_pkg::OUT_CNT_W-1:0] cnt_q;
	logic                          rd;
	logic                          wr;

	assign empty   = (cnt_q == '0);
	assign rd      = pop && !empty;
	// a transfer out this cycle frees a slot
	assign room    = (cnt_q != ppd_pkg::OUT_CNT_W'(ppd_pkg::OUT_DEPTH)) || rd;
	assign wr      = wr_en && room;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ sv/polyline_point_decoder_top.sv @@
// Encoded polyline decoder, top level.
// Depends on ppd_pkg, ppd_front, ppd_back and ppd_outq.
//
// Input channel: char_byte and last_char, one character of the encoded
// string per transfer, taken when push is high and full is low.
// Result channel: lat_e5, lng_e5, point_index and final_point show the oldest
// point while empty is low; pop high with empty low transfers it.
// Each character holds five data bits; a finished value is zigzag decoded
// and added to latitude, then longitude. A point leaves when its longitude
// is complete, and the last character always closes one final point.
// Throughput: one character per cycle while the receiver keeps taking results.
// The back end settles one character per cycle with a single 32-bit add after
// the value insert. A closing character is registered in the character queue,
// settled by the combinational back end when the result queue has room, and
// registered in the result queue, which then shows the point.
// Reset clears both queues and all decoder state; no clearing pass follows.
// When the receiver stalls, the two-entry result queue fills, the back end
// holds, then the character queue fills and full rises.
module polyline_point_decoder_top #(
	parameter int VALUE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         char_byte,
	input  logic               last_char,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] lat_e5,
	output logic signed [31:0] lng_e5,
	output logic [15:0]        point_index,
	output logic               final_point
);

	ppd_pkg::mid_item_t mid_item;
	logic               mid_valid;
	logic               mid_pop;
	logic               res_push;
	logic               res_room;
	ppd_pkg::result_t   res_in;
	ppd_pkg::result_t   res_out;

	ppd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.char_byte (char_byte),
		.last_char (last_char),
		.full      (full),
		.rd_en     (mid_pop),
		.rd_valid  (mid_valid),
		.rd_item   (mid_item)
	);

	ppd_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mid_valid),
		.in_item  (mid_item),
		.in_pop   (mid_pop),
		.out_room (res_room),
		.out_push (res_push),
		.out_data (res_in)
	);

	ppd_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.room    (res_room),
		.pop     (pop),
		.empty   (empty),
		.rd_data (res_out)
	);

	assign lat_e5      = res_out.lat_e5;
	assign lng_e5      = res_out.lng_e5;
	assign point_index = res_out.point_index;
	assign final_point = res_out.final_point;

endmodule
